### design/laps_pkg.sv
// ----------------------------------------------------------------------------
// LED animation point sequencer package
// Shared word types, command codes, flag positions and action codes.
// ----------------------------------------------------------------------------
package laps_pkg;

    localparam int VALUE_W  = 32;
    localparam int FLAGS_W  = 6;
    localparam int CFG_IDX_W = 1;

    // Commands carried in the input word.
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_WRITE   = 3'd1;
    localparam logic [2:0] CMD_TRIGGER = 3'd2;
    localparam logic [2:0] CMD_RESTART = 3'd3;
    localparam logic [2:0] CMD_ACTIVE  = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLES      = 1'b1;

    // Bit positions in a point's flags.
    localparam int FL_FADE   = 0;
    localparam int FL_PULSE  = 1;
    localparam int FL_TRIG   = 2;
    localparam int FL_ONTIME = 3;
    localparam int FL_TONEXT = 4;
    localparam int FL_ATMAX  = 5;

    // Bit positions in the done flags of a tick.
    localparam int DF_FADE   = 0;
    localparam int DF_PULSE  = 1;
    localparam int DF_SWITCH = 2;

    localparam logic [1:0] FADE_KEEP  = 2'd0;
    localparam logic [1:0] FADE_PLAIN = 2'd1;
    localparam logic [1:0] FADE_MODE  = 2'd2;

    localparam logic [1:0] PULSE_NONE = 2'd0;
    localparam logic [1:0] PULSE_LOAD = 2'd1;
    localparam logic [1:0] PULSE_OFF  = 2'd2;

    localparam logic [1:0] TRIG_IDLE  = 2'd0;
    localparam logic [1:0] TRIG_READY = 2'd1;
    localparam logic [1:0] TRIG_FIRED = 2'd2;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [VALUE_W-1:0] value;
        logic [2:0]         done_flags;
        logic [3:0]         point_index;
        logic [FLAGS_W-1:0] point_flags;
        logic               active_value;
    } laps_in_t;

    typedef struct packed {
        logic       loaded;
        logic [3:0] current_index;
        logic [1:0] fade_action;
        logic       switch_at_max;
        logic [1:0] pulse_action;
        logic [1:0] late_pulse_action;
        logic       is_active;
        logic       trigger_ready;
    } laps_out_t;

    typedef struct packed {
        logic do_load;
        logic first;
        logic late_en;
        logic switch_done;
        logic fading;
    } load_ctl_t;

    typedef struct packed {
        logic       loaded;
        logic [1:0] fade_action;
        logic       switch_at_max;
        logic [1:0] pulse_action;
        logic [1:0] late_pulse_action;
        logic       fading;
    } load_res_t;

endpackage

### design/led_animation_point_sequencer_core.sv
// ----------------------------------------------------------------------------
// LED animation point sequencer core
// Steps one animation sequence through a table of points on tick words.
// ----------------------------------------------------------------------------
// The s_ channel takes command words: ticks with the current time and the
// segment's done flags, point table writes, manual triggers, restarts and
// active changes. Every accepted word gives exactly one m_ word that tells
// whether a point was loaded and which fade and pulse actions to take.
// The cfg channel writes point_count (index 0) and cycle_setting (index 1);
// it is always ready; the user must write it only while the core is idle,
// which the core itself does not enforce. One word is in work at a time:
// the core accepts a new word only in its idle state, after the last word's
// result has gone to the output register. Each word takes two dependent
// reads of the point table, which has one registered read port: the current
// point first, then the point the sequence advanced to.
// A result waits in the output register while m_ready is low; the core
// still accepts the next word, and holds that word's result until the
// output register is free.
// Reset clears the sequence state and configuration; the point table has no
// reset and must be written before points are used.
// ----------------------------------------------------------------------------
module led_animation_point_sequencer_core #(
    parameter int MAX_POINTS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  laps_pkg::laps_in_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output laps_pkg::laps_out_t                  m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [laps_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [laps_pkg::VALUE_W-1:0]         cfg_data
);
    import laps_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = ($clog2(MAX_POINTS + 1) > 5) ? $clog2(MAX_POINTS + 1) : 5;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);
    localparam int MEM_W = FLAGS_W + VALUE_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0]         state_reg, state_next;
    laps_in_t           in_reg, in_next;
    laps_out_t          out_reg, out_next;
    logic               out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]   point_now_reg, point_now_next;
    logic [VALUE_W-1:0] cycles_reg, cycles_next;
    logic               running_reg, running_next;
    logic [1:0]         trig_reg, trig_next;
    logic [VALUE_W-1:0] release_reg, release_next;
    logic               fading_reg, fading_next;
    logic [4:0]         point_count_reg, point_count_next;
    logic [VALUE_W-1:0] cycle_setting_reg, cycle_setting_next;
    logic               do_load_reg, do_load_next;
    logic               first_reg, first_next;
    logic               late_en_reg, late_en_next;

    logic [MEM_W-1:0]   table_mem [MAX_POINTS];
    logic [MEM_W-1:0]   rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               mem_we;

    logic [FLAGS_W-1:0] cur_flags;
    logic [VALUE_W-1:0] cur_wait;
    logic [CNT_W-1:0]   used_points;
    logic [CNT_W-1:0]   next_point;
    logic               finish;
    load_ctl_t          load_ctl;
    load_res_t          load_res;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    assign cur_flags   = rd_data_reg[MEM_W-1:VALUE_W];
    assign cur_wait    = rd_data_reg[VALUE_W-1:0];
    assign used_points = (CNT_W'(point_count_reg) > MAX_CNT) ? MAX_CNT
                                                             : CNT_W'(point_count_reg);
    assign next_point  = CNT_W'(point_now_reg) + CNT_W'(1);
    assign finish      = (state_reg == S_LOAD) && (!out_valid_reg || m_ready);
    assign rd_addr     = (state_reg == S_EVAL) ? point_now_next : point_now_reg;
    assign mem_we      = (state_reg == S_EVAL) && (in_reg.cmd == CMD_WRITE)
                         && (CNT_W'(in_reg.point_index) < MAX_CNT);

    // Point table: flags above the wait time, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[IDX_W'(in_reg.point_index)] <= {in_reg.point_flags, in_reg.value};
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    assign load_ctl = '{do_load:     do_load_reg,
                        first:       first_reg,
                        late_en:     late_en_reg,
                        switch_done: in_reg.done_flags[DF_SWITCH],
                        fading:      fading_reg};

    laps_load_decode u_load_decode (
        .ctl_i   (load_ctl),
        .flags_i (cur_flags),
        .res_o   (load_res)
    );

    always_comb begin
        logic [VALUE_W-1:0] rel;
        logic [1:0]         trig_v;
        logic               rdy;
        logic               fade_done;
        logic               pulse_done;

        state_next         = state_reg;
        in_next            = in_reg;
        out_next           = out_reg;
        out_valid_next     = out_valid_reg;
        point_now_next     = point_now_reg;
        cycles_next        = cycles_reg;
        running_next       = running_reg;
        trig_next          = trig_reg;
        release_next       = release_reg;
        fading_next        = fading_reg;
        point_count_next   = point_count_reg;
        cycle_setting_next = cycle_setting_reg;
        do_load_next       = do_load_reg;
        first_next         = first_reg;
        late_en_next       = late_en_reg;
        rel                = release_reg;
        trig_v             = trig_reg;
        rdy                = 1'b0;
        fade_done          = 1'b0;
        pulse_done         = 1'b0;

        if (cfg_valid) begin
            case (cfg_addr)
                CFG_POINT_COUNT: point_count_next = cfg_data[4:0];
                CFG_CYCLES:      cycle_setting_next = cfg_data;
                default:         ;
            endcase
        end

        if (m_valid && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                do_load_next = 1'b0;
                first_next   = 1'b0;
                late_en_next = 1'b0;
                case (in_reg.cmd)
                    CMD_TICK: begin
                        if (running_reg && (used_points != '0)) begin
                            late_en_next = 1'b1;
                            fade_done  = in_reg.done_flags[DF_FADE] || !cur_flags[FL_FADE];
                            pulse_done = in_reg.done_flags[DF_PULSE] || !cur_flags[FL_PULSE];
                            if ((fade_done && pulse_done) || cur_flags[FL_ONTIME]) begin
                                rdy = 1'b1;
                                if (cur_flags[FL_TRIG]) begin
                                    if (trig_reg == TRIG_IDLE) begin
                                        trig_v = TRIG_READY;
                                    end
                                    rdy = (trig_v == TRIG_FIRED);
                                end
                                trig_next = trig_v;
                                if (rdy) begin
                                    // A release time of zero means no wait is pending yet.
                                    rel = (release_reg == '0) ? (cur_wait + in_reg.value)
                                                              : release_reg;
                                    if (rel <= in_reg.value) begin
                                        release_next = '0;
                                        if (next_point >= used_points) begin
                                            point_now_next = '0;
                                            if (cycles_reg != '0) begin
                                                cycles_next = cycles_reg - VALUE_W'(1);
                                                if (cycles_reg == VALUE_W'(1)) begin
                                                    running_next = 1'b0;
                                                end
                                            end
                                        end else begin
                                            point_now_next = IDX_W'(next_point);
                                        end
                                        do_load_next = running_next;
                                    end else begin
                                        release_next = rel;
                                    end
                                end
                            end
                        end
                    end
                    CMD_TRIGGER: begin
                        if (trig_reg == TRIG_READY) begin
                            trig_next = TRIG_FIRED;
                        end
                    end
                    CMD_RESTART: begin
                        cycles_next    = cycle_setting_reg;
                        point_now_next = '0;
                        running_next   = 1'b1;
                        do_load_next   = 1'b1;
                        first_next     = 1'b1;
                    end
                    CMD_ACTIVE: begin
                        running_next = in_reg.active_value;
                    end
                    default: ;
                endcase
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (finish) begin
                    fading_next = load_res.fading;
                    if (load_res.loaded) begin
                        trig_next = TRIG_IDLE;
                    end
                    out_next.loaded            = load_res.loaded;
                    out_next.current_index     = 4'(point_now_reg);
                    out_next.fade_action       = load_res.fade_action;
                    out_next.switch_at_max     = load_res.switch_at_max;
                    out_next.pulse_action      = load_res.pulse_action;
                    out_next.late_pulse_action = load_res.late_pulse_action;
                    out_next.is_active         = running_reg;
                    out_next.trigger_ready     = load_res.loaded ? 1'b0
                                                                 : (trig_reg == TRIG_READY);
                    out_valid_next             = 1'b1;
                    state_next                 = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            out_valid_reg     <= 1'b0;
            point_now_reg     <= '0;
            cycles_reg        <= '0;
            running_reg       <= 1'b0;
            trig_reg          <= TRIG_IDLE;
            release_reg       <= '0;
            fading_reg        <= 1'b0;
            point_count_reg   <= '0;
            cycle_setting_reg <= '0;
            do_load_reg       <= 1'b0;
            first_reg         <= 1'b0;
            late_en_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            out_valid_reg     <= out_valid_next;
            point_now_reg     <= point_now_next;
            cycles_reg        <= cycles_next;
            running_reg       <= running_next;
            trig_reg          <= trig_next;
            release_reg       <= release_next;
            fading_reg        <= fading_next;
            point_count_reg   <= point_count_next;
            cycle_setting_reg <= cycle_setting_next;
            do_load_reg       <= do_load_next;
            first_reg         <= first_next;
            late_en_reg       <= late_en_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg  <= in_next;
        out_reg <= out_next;
    end

    // An accepted word always goes straight to evaluation.
    a_accept_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_EVAL))
        else $error("accepted word did not enter evaluation");

    // A point is only loaded while the sequence runs.
    a_load_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.loaded) |-> m_data.is_active)
        else $error("point loaded while sequence inactive");

    // The current point never leaves the table.
    a_point_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (CNT_W'(point_now_reg) < MAX_CNT))
        else $error("current point out of table range");

    // A result held by a stalled receiver is not overwritten.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(out_reg))
        else $error("stalled result changed");

endmodule

### design/laps_load_decode.sv
// ----------------------------------------------------------------------------
// Point load decoder
// Turns the flags of the point just reached into fade and pulse actions,
// and resolves the late pulse once the mode-change fade has switched.
// ----------------------------------------------------------------------------
module laps_load_decode (
    input  laps_pkg::load_ctl_t ctl_i,
    input  logic [5:0]          flags_i,
    output laps_pkg::load_res_t res_o
);
    import laps_pkg::*;

    logic fading_mid;

    always_comb begin
        res_o      = '0;
        fading_mid = ctl_i.fading;
        if (ctl_i.do_load) begin
            res_o.loaded = 1'b1;
            if (flags_i[FL_FADE]) begin
                if (flags_i[FL_TONEXT] || ctl_i.first) begin
                    res_o.fade_action   = FADE_MODE;
                    res_o.switch_at_max = flags_i[FL_ATMAX];
                    fading_mid          = 1'b1;
                end else begin
                    res_o.fade_action = FADE_PLAIN;
                end
            end
            // While a mode-change fade runs, the pulse waits for the switch, except on the first load after a restart.
            if (!fading_mid || ctl_i.first) begin
                res_o.pulse_action = flags_i[FL_PULSE] ? PULSE_LOAD : PULSE_OFF;
            end
        end
        res_o.fading = fading_mid;
        if (ctl_i.late_en && fading_mid && ctl_i.switch_done) begin
            res_o.late_pulse_action = flags_i[FL_PULSE] ? PULSE_LOAD : PULSE_OFF;
            res_o.fading            = 1'b0;
        end
    end

endmodule
